### sv/dasc_pkg.sv
// Shared types, codes and default sizes for the decimal add / subtract / compare unit.
`default_nettype none
package dasc_pkg;

   localparam int FIELD_W         = 48;
   localparam int FIELD_DIGITS    = 12;
   localparam int INT_DIGITS_DEF  = 12;
   localparam int FRAC_DIGITS_DEF = 12;

   // Operation codes
   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_CMP = 2'd2;

   // Compare outcome codes
   localparam logic [1:0] ORD_EQ = 2'd0;
   localparam logic [1:0] ORD_LT = 2'd1;
   localparam logic [1:0] ORD_GT = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic               a_neg;
      logic [FIELD_W-1:0] a_int;
      logic [FIELD_W-1:0] a_frac;
      logic               b_neg;
      logic [FIELD_W-1:0] b_int;
      logic [FIELD_W-1:0] b_frac;
   } req_type;

   typedef struct packed {
      logic               r_neg;
      logic [FIELD_W-1:0] r_int;
      logic [FIELD_W-1:0] r_frac;
      logic [1:0]         order;
      logic [1:0]         status;
   } rsp_type;

endpackage
`default_nettype wire

### sv/dasc_core.sv
// Combinational datapath: digit check, signed compare, and decimal add or subtract.
`default_nettype none
module dasc_core #(
   parameter int INT_DIGITS  = dasc_pkg::INT_DIGITS_DEF,
   parameter int FRAC_DIGITS = dasc_pkg::FRAC_DIGITS_DEF
) (
   input  dasc_pkg::req_type op,
   output dasc_pkg::rsp_type res
);
   import dasc_pkg::*;

   localparam int TOT = INT_DIGITS + FRAC_DIGITS;
   localparam int W   = 4 * TOT;

   logic [63:0]  a_int_x, a_frac_x, b_int_x, b_frac_x;
   logic [W-1:0] mag_a, mag_b;
   logic         bad;
   logic         a_zero, b_zero, a_eq, a_gt;
   logic         an, bn, bn_eff, same, a_lt, r_neg;
   logic [1:0]   ord;
   logic [W-1:0] big, lesser, y;
   logic         cin;
   logic [W:0]   t1, t2, t3, t4;
   logic [W-1:0] dr;
   logic         cout;
   logic [63:0]  ri_x, rf_x;

   assign a_int_x  = {16'd0, op.a_int};
   assign a_frac_x = {16'd0, op.a_frac};
   assign b_int_x  = {16'd0, op.b_int};
   assign b_frac_x = {16'd0, op.b_frac};

   // Gather the used digits, least significant fraction digit in nibble 0.
   always_comb begin
      mag_a = '0;
      mag_b = '0;
      for (int k = 0; k < FRAC_DIGITS; k++) begin
         mag_a[4*k +: 4] = a_frac_x[4*k +: 4];
         mag_b[4*k +: 4] = b_frac_x[4*k +: 4];
      end
      for (int k = 0; k < INT_DIGITS; k++) begin
         mag_a[4*(FRAC_DIGITS+k) +: 4] = a_int_x[4*k +: 4];
         mag_b[4*(FRAC_DIGITS+k) +: 4] = b_int_x[4*k +: 4];
      end
   end

   always_comb begin
      bad = 1'b0;
      for (int k = 0; k < TOT; k++) begin
         if (mag_a[4*k +: 4] > 4'd9 || mag_b[4*k +: 4] > 4'd9) begin
            bad = 1'b1;
         end
      end
   end

   // Valid packed BCD orders the same as plain binary.
   assign a_zero = (mag_a == '0);
   assign b_zero = (mag_b == '0);
   assign a_eq   = (mag_a == mag_b);
   assign a_gt   = (mag_a > mag_b);
   assign a_lt   = !a_gt && !a_eq;
   assign an     = op.a_neg && !a_zero;
   assign bn     = op.b_neg && !b_zero;

   always_comb begin
      if (an != bn) begin
         ord = an ? ORD_LT : ORD_GT;
      end else if (a_eq) begin
         ord = ORD_EQ;
      end else begin
         ord = (a_gt ^ an) ? ORD_GT : ORD_LT;
      end
   end

   assign bn_eff = (op.action == ACT_SUB) ? (bn ^ !b_zero) : bn;
   assign same   = (an == bn_eff);
   assign big    = (!same && a_lt) ? mag_b : mag_a;
   assign lesser = (!same && a_lt) ? mag_a : mag_b;

   // Subtract as big plus nines' complement of lesser plus one.
   always_comb begin
      y = lesser;
      if (!same) begin
         for (int k = 0; k < TOT; k++) begin
            y[4*k +: 4] = 4'd9 - lesser[4*k +: 4];
         end
      end
   end
   assign cin = !same;

   // Packed BCD add: bias by six, binary add, take six back where no digit carry.
   assign t1 = {1'b0, big} + {1'b0, {TOT{4'h6}}};
   assign t2 = t1 + {1'b0, y} + {{W{1'b0}}, cin};
   assign t3 = t1 ^ {1'b0, y};
   assign t4 = t2 ^ t3;

   always_comb begin
      for (int k = 0; k < TOT; k++) begin
         dr[4*k +: 4] = t4[4*k+4] ? t2[4*k +: 4] : (t2[4*k +: 4] - 4'd6);
      end
   end
   assign cout = t4[W];

   always_comb begin
      r_neg = (!same && a_lt) ? bn_eff : an;
      if (dr == '0) begin
         r_neg = 1'b0;
      end
   end

   always_comb begin
      ri_x = '0;
      rf_x = '0;
      for (int k = 0; k < FRAC_DIGITS; k++) begin
         rf_x[4*k +: 4] = dr[4*k +: 4];
      end
      for (int k = 0; k < INT_DIGITS; k++) begin
         ri_x[4*k +: 4] = dr[4*(FRAC_DIGITS+k) +: 4];
      end
   end

   always_comb begin
      res = '0;
      if (bad) begin
         res.status = ST_BAD;
      end else if (op.action == ACT_ADD || op.action == ACT_SUB) begin
         res.r_neg  = r_neg;
         res.r_int  = ri_x[FIELD_W-1:0];
         res.r_frac = rf_x[FIELD_W-1:0];
         res.status = (same && cout) ? ST_OVF : ST_OK;
      end else begin
         res.order = ord;
      end
   end

endmodule
`default_nettype wire

### sv/decimal_add_sub_compare.sv
// Top level: operand register, decimal datapath and result register.
//
//  channel | ports                          | beat
//  --------+--------------------------------+--------------------------------------
//  request | req_valid, req_ready, req      | operation, two signed BCD operands
//  result  | rsp_valid, rsp_ready, rsp      | sign, digits, order, status
//
// One beat per cycle sustained while results are not stalled; each request beat
// is held in the operand register, then its result in the result register.
// The datapath between the two registers is one decimal adder pass.
// Reset empties both registers. A stalled result holds the result register and
// the operand register still takes one more beat behind it.
`default_nettype none
module decimal_add_sub_compare #(
   parameter int INT_DIGITS  = dasc_pkg::INT_DIGITS_DEF,
   parameter int FRAC_DIGITS = dasc_pkg::FRAC_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dasc_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dasc_pkg::rsp_type rsp
);
   import dasc_pkg::*;

   logic    op_v_ff, op_v_in;
   logic    res_v_ff, res_v_in;
   req_type op_ff;
   rsp_type res_ff, res_comb;
   logic    res_load, op_load;

   dasc_core #(
      .INT_DIGITS  (INT_DIGITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_core (
      .op  (op_ff),
      .res (res_comb)
   );

   // Advance the operand stage whenever the result register is free or draining.
   assign res_load  = op_v_ff && (!res_v_ff || rsp_ready);
   assign req_ready = !op_v_ff || res_load;
   assign op_load   = req_valid && req_ready;

   assign op_v_in  = op_load || (op_v_ff && !res_load);
   assign res_v_in = res_load || (res_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_v_ff  <= 1'b0;
         res_v_ff <= 1'b0;
      end else begin
         op_v_ff  <= op_v_in;
         res_v_ff <= res_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_load) begin
         op_ff <= req;
      end
      if (res_load) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_valid = res_v_ff;
   assign rsp       = res_ff;

`ifndef SYNTHESIS
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (op_v_ff && res_v_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while both stages are stalled");

   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> op_v_ff)
      else $error("accepted request beat lost");

   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_BAD) |->
         (!rsp.r_neg && rsp.r_int == '0 && rsp.r_frac == '0 && rsp.order == ORD_EQ))
      else $error("invalid digit result carries data");

   a_order_only_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.order != ORD_EQ) |->
         (rsp.status == ST_OK && !rsp.r_neg && rsp.r_int == '0 && rsp.r_frac == '0))
      else $error("compare result mixed with arithmetic fields");
`endif

endmodule
`default_nettype wire
